>>> rtl/core/srpm_pkg.sv
// shared types and constants for the sphere point mapper
package srpm_pkg;

  localparam int FracBits  = 16;
  localparam int NumStages = 24;
  localparam int RootFirst = 3;
  localparam int RootLast  = 19;
  localparam int FinStage  = 20;

  // pi in q2.30, used to scale a 14-bit quarter-turn phase into radians
  localparam logic [31:0] PiQ30 = 32'd3373259426;

  // register index codes
  typedef enum logic [2:0] {
    REG_CENTER_X   = 3'd0,
    REG_CENTER_Y   = 3'd1,
    REG_CENTER_Z   = 3'd2,
    REG_RADIUS     = 3'd3,
    REG_SHELL_MODE = 3'd4
  } srpm_reg_e;

  typedef struct packed {
    logic [31:0] center_x;
    logic [31:0] center_y;
    logic [31:0] center_z;
    logic [30:0] radius;
    logic        shell_mode;
  } srpm_cfg_t;

  // taylor divisors for sine term t
  function automatic logic [6:0] sin_div(input int t);
    logic [6:0] d;
    case (t)
      1:       d = 7'd6;
      2:       d = 7'd20;
      3:       d = 7'd42;
      4:       d = 7'd72;
      default: d = 7'd110;
    endcase
    return d;
  endfunction

  // taylor divisors for cosine term t
  function automatic logic [6:0] cos_div(input int t);
    logic [6:0] d;
    case (t)
      1:       d = 7'd2;
      2:       d = 7'd12;
      3:       d = 7'd30;
      4:       d = 7'd56;
      default: d = 7'd90;
    endcase
    return d;
  endfunction

  // floor(2^32 / sine divisor)
  function automatic logic [31:0] sin_rcp(input int t);
    logic [31:0] m;
    case (t)
      1:       m = 32'd715827882;
      2:       m = 32'd214748364;
      3:       m = 32'd102261126;
      4:       m = 32'd59652323;
      default: m = 32'd39045157;
    endcase
    return m;
  endfunction

  // floor(2^32 / cosine divisor)
  function automatic logic [31:0] cos_rcp(input int t);
    logic [31:0] m;
    case (t)
      1:       m = 32'd2147483648;
      2:       m = 32'd357913941;
      3:       m = 32'd143165576;
      4:       m = 32'd76695844;
      default: m = 32'd47721858;
    endcase
    return m;
  endfunction

endpackage

>>> rtl/core/srpm_datapath.sv
// pipelined datapath: roots, taylor sine/cosine, scaling and saturation
module srpm_datapath import srpm_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  srpm_cfg_t   cfg_i,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [15:0] rand_polar_i,
  input  logic [15:0] rand_depth_i,
  input  logic [15:0] rand_angle_i,
  input  logic        last_in_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [31:0] point_x_o,
  output logic [31:0] point_y_o,
  output logic [31:0] point_z_o,
  output logic        last_out_o
);

  typedef struct packed {
    logic               last;
    logic               shell;
    logic [15:0]        u2;
    logic signed [17:0] cosphi;
    logic [16:0]        mag;
    logic [1:0]         quad;
    logic               swap;
    logic [13:0]        a;
    logic [33:0]        msq;
    logic [29:0]        x;
    logic [29:0]        x2;
    logic [34:0]        sq_rem;
    logic [16:0]        sq_y;
    logic [47:0]        cb_rem;
    logic [15:0]        cb_y;
    logic [31:0]        cb_y2;
    logic [30:0]        ts;
    logic [30:0]        tc;
    logic [30:0]        ns;
    logic [30:0]        nc;
    logic [30:0]        qs;
    logic [30:0]        qc;
    logic signed [31:0] s;
    logic signed [31:0] c;
    logic signed [17:0] st;
    logic signed [17:0] ct;
    logic [16:0]        h;
    logic signed [17:0] vz;
    logic signed [17:0] hx;
    logic signed [17:0] hy;
    logic signed [32:0] ox;
    logic signed [32:0] oy;
    logic signed [32:0] oz;
    logic [31:0]        px;
    logic [31:0]        py;
    logic [31:0]        pz;
  } pipe_t;

  // q.16 product, magnitude rounded half up, sign from b
  function automatic logic signed [17:0] mul_frac(input logic [16:0] a,
                                                 input logic signed [17:0] b);
    logic [16:0] m;
    logic [34:0] p;
    logic [17:0] r;
    m = b[17] ? 17'(-b) : b[16:0];
    p = 35'(a) * 35'(m) + 35'(1 << (FracBits - 1));
    r = p[33:16];
    return b[17] ? $signed(-r) : $signed(r);
  endfunction

  // radius times a q.16 value
  function automatic logic signed [32:0] mul_rad(input logic [30:0] a,
                                                input logic signed [17:0] b);
    logic [16:0] m;
    logic [48:0] p;
    logic [32:0] r;
    m = b[17] ? 17'(-b) : b[16:0];
    p = 49'(a) * 49'(m) + 49'(1 << (FracBits - 1));
    r = {1'b0, p[47:16]};
    return b[17] ? $signed(-r) : $signed(r);
  endfunction

  // q2.30 to q.16, magnitude rounded half up
  function automatic logic signed [17:0] q30_round(input logic signed [31:0] v);
    logic [31:0] m;
    logic [31:0] r;
    m = v[31] ? 32'(-v) : v;
    r = (m + 32'(1 << (29 - FracBits))) >> (30 - FracBits);
    return v[31] ? $signed(-r[17:0]) : $signed(r[17:0]);
  endfunction

  // center plus offset, clamped to signed 32 bits
  function automatic logic [31:0] sat_add(input logic [31:0] cen,
                                          input logic signed [32:0] off);
    logic signed [33:0] sum;
    logic [31:0] r;
    sum = 34'($signed(cen)) + 34'(off);
    if (sum > 34'sh0_7FFF_FFFF) r = 32'h7FFF_FFFF;
    else if (sum < -34'sh0_8000_0000) r = 32'h8000_0000;
    else r = sum[31:0];
    return r;
  endfunction

  // work done by register stage k
  function automatic pipe_t step(input pipe_t p, input int k, input srpm_cfg_t cfg);
    pipe_t o;
    logic [45:0] px46;
    logic [59:0] p60;
    logic [60:0] p61;
    logic [62:0] p63;
    logic [35:0] dsq;
    logic [50:0] dcb;
    logic [37:0] rem;
    logic [16:0] dep;
    logic signed [17:0] sv;
    logic signed [17:0] cv;
    int j;
    int b;
    int t;
    o = p;
    j = k - RootFirst;
    if (k == 1) begin
      o.msq = 34'(p.mag) * 34'(p.mag);
      px46 = 46'(p.a) * 46'(PiQ30);
      o.x = px46[44:15];
    end else if (k == 2) begin
      o.sq_rem = 35'(64'd1 << (2 * FracBits)) - 35'(p.msq);
      o.sq_y = '0;
      o.cb_rem = {p.u2, 32'd0};
      o.cb_y = '0;
      o.cb_y2 = '0;
      p60 = 60'(p.x) * 60'(p.x);
      o.x2 = p60[59:30];
      o.ts = {1'b0, p.x};
      o.tc = 31'(1 << 30);
      o.s = 32'(p.x);
      o.c = 32'sd1073741824;
    end else if (k >= RootFirst && k <= RootLast) begin
      // one square-root bit
      b = FracBits - j;
      dsq = (36'(p.sq_y) << (b + 1)) + (36'd1 << (2 * b));
      if (dsq <= 36'(p.sq_rem)) begin
        o.sq_rem = 35'(36'(p.sq_rem) - dsq);
        o.sq_y = p.sq_y | 17'(1 << b);
      end
      // one cube-root bit
      if (j < FracBits) begin
        b = FracBits - 1 - j;
        dcb = ((51'(p.cb_y2) + (51'(p.cb_y2) << 1)) << b)
            + ((51'(p.cb_y) + (51'(p.cb_y) << 1)) << (2 * b))
            + (51'd1 << (3 * b));
        if (dcb <= 51'(p.cb_rem)) begin
          o.cb_rem = 48'(51'(p.cb_rem) - dcb);
          o.cb_y2 = 32'(33'(p.cb_y2) + (33'(p.cb_y) << (b + 1)) + (33'd1 << (2 * b)));
          o.cb_y = p.cb_y | 16'(1 << b);
        end
      end
      // one third of a taylor term
      if (j < 15) begin
        t = j / 3 + 1;
        case (j % 3)
          0: begin
            p61 = 61'(p.ts) * 61'(p.x2);
            o.ns = p61[60:30];
            p61 = 61'(p.tc) * 61'(p.x2);
            o.nc = p61[60:30];
          end
          1: begin
            p63 = 63'(p.ns) * 63'(sin_rcp(t));
            o.qs = p63[62:32];
            p63 = 63'(p.nc) * 63'(cos_rcp(t));
            o.qc = p63[62:32];
          end
          default: begin
            rem = 38'(p.ns) - 38'(p.qs) * 38'(sin_div(t));
            o.ts = (rem >= 38'(sin_div(t))) ? p.qs + 31'd1 : p.qs;
            rem = 38'(p.nc) - 38'(p.qc) * 38'(cos_div(t));
            o.tc = (rem >= 38'(cos_div(t))) ? p.qc + 31'd1 : p.qc;
            if (t % 2 == 1) begin
              o.s = p.s - $signed(32'(o.ts));
              o.c = p.c - $signed(32'(o.tc));
            end else begin
              o.s = p.s + $signed(32'(o.ts));
              o.c = p.c + $signed(32'(o.tc));
            end
          end
        endcase
      end
    end else if (k == FinStage) begin
      sv = q30_round(p.swap ? p.c : p.s);
      cv = q30_round(p.swap ? p.s : p.c);
      unique case (p.quad)
        2'd0: begin o.ct = cv;  o.st = sv;  end
        2'd1: begin o.ct = -sv; o.st = cv;  end
        2'd2: begin o.ct = -cv; o.st = -sv; end
        default: begin o.ct = sv; o.st = -cv; end
      endcase
      dep = p.shell ? 17'(1 << FracBits) : {1'b0, p.cb_y};
      o.h = 17'(mul_frac(dep, $signed({1'b0, p.sq_y})));
      o.vz = mul_frac(dep, p.cosphi);
    end else if (k == FinStage + 1) begin
      o.hx = mul_frac(p.h, p.ct);
      o.hy = mul_frac(p.h, p.st);
    end else if (k == FinStage + 2) begin
      o.ox = mul_rad(cfg.radius, p.hx);
      o.oy = mul_rad(cfg.radius, p.hy);
      o.oz = mul_rad(cfg.radius, p.vz);
    end else begin
      o.px = sat_add(cfg.center_x, p.ox);
      o.py = sat_add(cfg.center_y, p.oy);
      o.pz = sat_add(cfg.center_z, p.oz);
    end
    return o;
  endfunction

  logic  v_q [NumStages];
  logic  en  [NumStages];
  pipe_t p_q [NumStages];
  pipe_t p_d [NumStages];
  pipe_t p_in;
  logic [13:0] rphase;

  // input preparation: polar cosine and phase folding
  always_comb begin
    p_in = '0;
    rphase = rand_angle_i[13:0];
    p_in.last = last_in_i;
    p_in.shell = cfg_i.shell_mode;
    p_in.u2 = rand_depth_i;
    p_in.cosphi = $signed(18'(1 << FracBits)) - $signed({1'b0, rand_polar_i, 1'b0});
    p_in.mag = p_in.cosphi[17] ? 17'(-p_in.cosphi) : p_in.cosphi[16:0];
    p_in.quad = rand_angle_i[15:14];
    p_in.swap = rphase > 14'd8192;
    p_in.a = p_in.swap ? 14'(15'd16384 - {1'b0, rphase}) : rphase;
  end

  // per-stage enables: a stage moves when empty or when its successor moves
  always_comb begin
    en[NumStages-1] = !v_q[NumStages-1] || out_ready_i;
    for (int i = NumStages - 2; i >= 0; i--) begin
      en[i] = !v_q[i] || en[i+1];
    end
  end

  assign p_d[0] = p_in;

  for (genvar k = 1; k < NumStages; k++) begin : g_stage
    always_comb begin
      p_d[k] = step(p_q[k-1], k, cfg_i);
    end
  end

  // stage valid bits
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < NumStages; i++) v_q[i] <= 1'b0;
    end else begin
      if (en[0]) v_q[0] <= in_valid_i;
      for (int i = 1; i < NumStages; i++) begin
        if (en[i]) v_q[i] <= v_q[i-1];
      end
    end
  end

  // stage payload
  always_ff @(posedge clk_i) begin
    for (int i = 0; i < NumStages; i++) begin
      if (en[i]) p_q[i] <= p_d[i];
    end
  end

  assign in_ready_o  = en[0];
  assign out_valid_o = v_q[NumStages-1];
  assign point_x_o   = p_q[NumStages-1].px;
  assign point_y_o   = p_q[NumStages-1].py;
  assign point_z_o   = p_q[NumStages-1].pz;
  assign last_out_o  = p_q[NumStages-1].last;

endmodule

>>> rtl/core/sphere_random_point_mapper_top.sv
// throughput: one word per cycle while the output is not stalled
// depth: set by the 17-step square-root chain
// stalls: each full stage holds while its successor holds, bubbles are squeezed out
// reset: pipeline emptied, center 0, radius 32768, volume mode
// top level: configuration registers and the point pipeline
module sphere_random_point_mapper_top import srpm_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [2:0]  cfg_idx_i,
  input  logic [31:0] cfg_data_i,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [15:0] rand_polar_i,
  input  logic [15:0] rand_depth_i,
  input  logic [15:0] rand_angle_i,
  input  logic        last_in_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [31:0] point_x_o,
  output logic [31:0] point_y_o,
  output logic [31:0] point_z_o,
  output logic        last_out_o
);

  srpm_cfg_t cfg_q;

  // configuration writes
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.center_x   <= '0;
      cfg_q.center_y   <= '0;
      cfg_q.center_z   <= '0;
      cfg_q.radius     <= 31'd32768;
      cfg_q.shell_mode <= 1'b0;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        REG_CENTER_X:   cfg_q.center_x   <= cfg_data_i;
        REG_CENTER_Y:   cfg_q.center_y   <= cfg_data_i;
        REG_CENTER_Z:   cfg_q.center_z   <= cfg_data_i;
        REG_RADIUS:     cfg_q.radius     <= cfg_data_i[30:0];
        REG_SHELL_MODE: cfg_q.shell_mode <= cfg_data_i[0];
        default: ;
      endcase
    end
  end

  srpm_datapath u_datapath (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_i        (cfg_q),
    .in_valid_i   (in_valid_i),
    .in_ready_o   (in_ready_o),
    .rand_polar_i (rand_polar_i),
    .rand_depth_i (rand_depth_i),
    .rand_angle_i (rand_angle_i),
    .last_in_i    (last_in_i),
    .out_valid_o  (out_valid_o),
    .out_ready_i  (out_ready_i),
    .point_x_o    (point_x_o),
    .point_y_o    (point_y_o),
    .point_z_o    (point_z_o),
    .last_out_o   (last_out_o)
  );

endmodule
